@@ rtl/bounded_deque_with_sort_defines.svh @@
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shared property templates for the deque checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SORT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SORT_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define BDQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define BDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// types, widths and codes of the bounded deque with sort
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int OP_W  = 3;
	localparam int ST_W  = 2;

	localparam int IN_BITS  = OP_W + KEY_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ST_W + 2 * KEY_W + CNT_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// field positions in the result tdata
	localparam int FRONT_LSB = ST_W;
	localparam int BACK_LSB  = ST_W + KEY_W;
	localparam int CNT_LSB   = ST_W + 2 * KEY_W;
	localparam int EMPTY_BIT = CNT_LSB + CNT_W;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SORT       = 3'd4,
		OP_CLEAR      = 3'd5,
		OP_QUERY      = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE      = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		key_t             wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		key_t             front_key;
		key_t             back_key;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
	} result_t;

endpackage

@@ rtl/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bdq_unit.sv @@
// ----------------------------------------------------------------------------
// bdq_unit
// shared ring address adder and signed key comparator
// ----------------------------------------------------------------------------
module bdq_unit (
	input  logic [bdq_pkg::IDX_W-1:0] front,
	input  logic [bdq_pkg::CNT_W-1:0] off,
	input  bdq_pkg::key_t             a,
	input  bdq_pkg::key_t             b,
	output logic [bdq_pkg::IDX_W-1:0] addr,
	output logic                      less
);

	localparam int SUM_W = bdq_pkg::CNT_W + 1;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;

	// front plus offset, folded back into the ring
	always_comb begin
		sum = SUM_W'(front) + SUM_W'(off);
		if (sum >= SUM_W'(bdq_pkg::DEPTH)) begin
			wrapped = sum - SUM_W'(bdq_pkg::DEPTH);
		end else begin
			wrapped = sum;
		end
	end

	assign addr = wrapped[bdq_pkg::IDX_W-1:0];
	assign less = (a < b);

endmodule

@@ rtl/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// sequencer of the deque: pushes, pops, clears, insertion sort and result reads
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bdq_pkg::OP_W-1:0]  in_op,
	input  bdq_pkg::key_t             in_key,
	output bdq_pkg::mem_req_t         mem,
	input  bdq_pkg::key_t             rdata,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bdq_pkg::result_t          res
);

	localparam int IDX_W = bdq_pkg::IDX_W;
	localparam int CNT_W = bdq_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SORT_RDI,
		S_SORT_V,
		S_SORT_CMP,
		S_SORT_RDJ,
		S_SORT_PUT,
		S_RD_FRONT,
		S_RD_BACK,
		S_DONE
	} state_t;

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     front_q, front_d;
	logic [CNT_W-1:0]     count_q, count_d;
	bdq_pkg::status_t     status_q, status_d;
	logic [CNT_W-1:0]     i_q, i_d;
	logic [CNT_W-1:0]     j_q, j_d;
	bdq_pkg::key_t        v_q, v_d;
	bdq_pkg::key_t        frontk_q, frontk_d;

	logic [CNT_W-1:0]     off;
	logic [IDX_W-1:0]     ring_addr;
	logic                 less;
	logic                 full;
	logic                 empty;
	logic [IDX_W-1:0]     front_dec;
	logic [IDX_W-1:0]     front_inc;
	logic [CNT_W-1:0]     i_next;

	bdq_unit u_unit (
		.front (front_q),
		.off   (off),
		.a     (v_q),
		.b     (rdata),
		.addr  (ring_addr),
		.less  (less)
	);

	assign full      = (count_q == CNT_W'(bdq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(bdq_pkg::DEPTH - 1) : front_q - IDX_W'(1);
	assign front_inc = (front_q == IDX_W'(bdq_pkg::DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
	assign i_next    = i_q + CNT_W'(1);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		status_d  = status_q;
		i_d       = i_q;
		j_d       = j_q;
		v_d       = v_q;
		frontk_d  = frontk_q;
		off       = count_q;
		mem.we    = 1'b0;
		mem.wdata = in_key;
		mem.waddr = ring_addr;
		mem.raddr = ring_addr;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				off      = count_q;
				if (in_valid) begin
					status_d = bdq_pkg::ST_DONE;
					state_d  = S_RD_FRONT;
					unique case (bdq_pkg::op_t'(in_op))
						bdq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								status_d = bdq_pkg::ST_PUSH_FULL;
							end else begin
								front_d   = front_dec;
								mem.we    = 1'b1;
								mem.waddr = front_dec;
								count_d   = count_q + CNT_W'(1);
							end
						end
						bdq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								status_d = bdq_pkg::ST_PUSH_FULL;
							end else begin
								mem.we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						bdq_pkg::OP_POP_FRONT: begin
							if (empty) begin
								status_d = bdq_pkg::ST_POP_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - CNT_W'(1);
							end
						end
						bdq_pkg::OP_POP_BACK: begin
							if (empty) begin
								status_d = bdq_pkg::ST_POP_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
							end
						end
						bdq_pkg::OP_SORT: begin
							if (count_q >= CNT_W'(2)) begin
								i_d     = CNT_W'(1);
								state_d = S_SORT_RDI;
							end
						end
						bdq_pkg::OP_CLEAR: begin
							count_d = '0;
							front_d = '0;
						end
						default: begin
						end
					endcase
					// nothing to read back from an empty queue
					if (state_d == S_RD_FRONT && count_d == '0) begin
						state_d = S_DONE;
					end
				end
			end
			S_SORT_RDI: begin
				off     = i_q;
				state_d = S_SORT_V;
			end
			S_SORT_V: begin
				// key to insert arrives, fetch its left neighbor
				off     = i_q - CNT_W'(1);
				v_d     = rdata;
				j_d     = i_q;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				off    = j_q;
				mem.we = 1'b1;
				if (less) begin
					// shift the larger neighbor one slot right
					mem.wdata = rdata;
					j_d       = j_q - CNT_W'(1);
					state_d   = (j_q == CNT_W'(1)) ? S_SORT_PUT : S_SORT_RDJ;
				end else begin
					mem.wdata = v_q;
					if (i_next < count_q) begin
						i_d     = i_next;
						state_d = S_SORT_RDI;
					end else begin
						state_d = S_RD_FRONT;
					end
				end
			end
			S_SORT_RDJ: begin
				off     = j_q - CNT_W'(1);
				state_d = S_SORT_CMP;
			end
			S_SORT_PUT: begin
				off       = '0;
				mem.we    = 1'b1;
				mem.wdata = v_q;
				if (i_next < count_q) begin
					i_d     = i_next;
					state_d = S_SORT_RDI;
				end else begin
					state_d = S_RD_FRONT;
				end
			end
			S_RD_FRONT: begin
				off     = '0;
				state_d = S_RD_BACK;
			end
			S_RD_BACK: begin
				off      = count_q - CNT_W'(1);
				frontk_d = rdata;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// keep the back address so read data holds while stalled
				off       = count_q - CNT_W'(1);
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.status      = status_q;
		res.front_key   = empty ? '1 : frontk_q;
		res.back_key    = empty ? '1 : rdata;
		res.entry_count = count_q;
		res.is_empty    = empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			status_q <= bdq_pkg::ST_DONE;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q      <= i_d;
		j_q      <= j_d;
		v_q      <= v_d;
		frontk_q <= frontk_d;
	end

endmodule

@@ rtl/bounded_deque_with_sort.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_sort
// bounded double-ended queue of signed keys with in-place ascending sort
// ----------------------------------------------------------------------------
// One transaction is taken at a time; s_tready is low until its result has
// been loaded into the output register. Push, pop, clear and query then read
// the front and back keys through the one registered read port of the key
// store; these reads are skipped when the queue is empty afterwards. A sort
// of n keys runs an insertion sort through that read port and one shared
// comparator. The output register lets the next transaction be taken while
// a result still waits on m_tready.
module bounded_deque_with_sort (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode [2:0], key [34:3], zero fill above
	input  logic [bdq_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status, front_key, back_key, entry_count, is_empty, from bit 0 up
	output logic [bdq_pkg::OUT_W-1:0] m_tdata
);

	bdq_pkg::mem_req_t mem;
	bdq_pkg::key_t     rdata;
	bdq_pkg::result_t  res;
	logic              res_valid;
	logic              res_ready;
	logic              m_tvalid_q;
	logic [bdq_pkg::OUT_W-1:0] m_tdata_q;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tdata[bdq_pkg::OP_W-1:0]),
		.in_key    (s_tdata[bdq_pkg::IN_BITS-1:bdq_pkg::OP_W]),
		.mem       (mem),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	bdq_ram #(
		.WIDTH (bdq_pkg::KEY_W),
		.DEPTH (bdq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= bdq_pkg::OUT_W'({res.is_empty, res.entry_count, res.back_key,
				res.front_key, res.status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/bdq_checker.sv @@
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks of the bounded deque, bound to the top level
// ----------------------------------------------------------------------------
`include "bounded_deque_with_sort_defines.svh"

module bdq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bdq_pkg::OUT_W-1:0] m_tdata
);

	localparam int KEY_W     = bdq_pkg::KEY_W;
	localparam int CNT_W     = bdq_pkg::CNT_W;
	localparam int FRONT_LSB = bdq_pkg::FRONT_LSB;
	localparam int BACK_LSB  = bdq_pkg::BACK_LSB;
	localparam int CNT_LSB   = bdq_pkg::CNT_LSB;
	localparam int EMPTY_BIT = bdq_pkg::EMPTY_BIT;
	localparam int DEPTH     = bdq_pkg::DEPTH;

	`BDQ_ASSERT_IMPL(a_empty_flag, clk, arst_n, m_tvalid,
		m_tdata[EMPTY_BIT] == (m_tdata[CNT_LSB +: CNT_W] == '0), "empty flag disagrees with count")

	`BDQ_ASSERT_IMPL(a_empty_keys, clk, arst_n, m_tvalid && m_tdata[EMPTY_BIT],
		m_tdata[FRONT_LSB +: KEY_W] == '1 && m_tdata[BACK_LSB +: KEY_W] == '1, "empty keys not -1")

	`BDQ_ASSERT_IMPL(a_count_bound, clk, arst_n, m_tvalid,
		m_tdata[CNT_LSB +: CNT_W] <= CNT_W'(DEPTH), "count above depth")

	`BDQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready,
		!s_tready, "ready right after an accepted transaction")

	`BDQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind bounded_deque_with_sort bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
